// File: src/rdm_pkg.sv
`default_nettype none
package rdm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CORDIC_ITER_DEF = 16;

    // angle accumulator: 2^-16 of 1/64 degree
    localparam int ZW           = 32;
    localparam int ORI_W        = 15;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [ZW-1:0] ANGLE_90  = 32'sd377487360;
    localparam logic signed [ZW-1:0] ORI_LIMIT = 32'sd11520;
    localparam logic signed [ZW-1:0] Z_HALF    = 32'sd32768;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 1'b1;

    function automatic logic signed [ZW-1:0] rdm_atan(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 32'sd188743680;
            1:  v = 32'sd111421900;
            2:  v = 32'sd58872272;
            3:  v = 32'sd29884485;
            4:  v = 32'sd15000234;
            5:  v = 32'sd7507429;
            6:  v = 32'sd3754631;
            7:  v = 32'sd1877430;
            8:  v = 32'sd938729;
            9:  v = 32'sd469366;
            10: v = 32'sd234683;
            11: v = 32'sd117342;
            12: v = 32'sd58671;
            13: v = 32'sd29335;
            14: v = 32'sd14668;
            15: v = 32'sd7334;
            16: v = 32'sd3667;
            17: v = 32'sd1833;
            18: v = 32'sd917;
            19: v = 32'sd458;
            20: v = 32'sd229;
            21: v = 32'sd115;
            22: v = 32'sd57;
            23: v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/rdm_intf.sv
`default_nettype none
interface rdm_in_if #(parameter int SB = 16);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] raw_x;
    logic signed [SB-1:0] raw_y;
    modport source (output valid, raw_x, raw_y, input ready);
    modport sink (input valid, raw_x, raw_y, output ready);
endinterface

interface rdm_out_if import rdm_pkg::*; #(parameter int SB = 16);
    logic                    valid;
    logic                    ready;
    logic signed [SB:0]      corrected_x;
    logic signed [SB:0]      corrected_y;
    logic [SB-1:0]           corrected_magnitude;
    logic signed [ORI_W-1:0] orientation;
    modport source (output valid, corrected_x, corrected_y, corrected_magnitude,
                    orientation, input ready);
    modport sink (input valid, corrected_x, corrected_y, corrected_magnitude,
                  orientation, output ready);
endinterface

interface rdm_cfg_if import rdm_pkg::*; #(parameter int SB = 16);
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SB-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/rdm_sqrt_cell.sv
`default_nettype none
// one digit of the integer square root
module rdm_sqrt_cell #(
    parameter int SB = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [2*SB-1:0] i_n,
    input  wire logic [SB+1:0]   i_rem,
    input  wire logic [SB-1:0]   i_root,
    output logic [2*SB-1:0]      o_n,
    output logic [SB+1:0]        o_rem,
    output logic [SB-1:0]        o_root
);
    logic [2*SB-1:0] r_n;
    logic [SB+1:0]   r_rem;
    logic [SB-1:0]   r_root;
    logic [SB+2:0]   w_sh;
    logic [SB+2:0]   w_trial;
    logic [SB+2:0]   w_diff;
    logic            w_ge;

    assign w_sh    = {i_rem[SB:0], i_n[2*SB-1 -: 2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = (w_sh >= w_trial);
    assign w_diff  = w_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= {i_n[2*SB-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[SB+1:0] : w_sh[SB+1:0];
            r_root <= {i_root[SB-2:0], w_ge};
        end
    end

    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

// File: src/rdm_div_cell.sv
`default_nettype none
// one quotient bit of a restoring division; remainder stays below divisor
module rdm_div_cell #(
    parameter int DW = 16,
    parameter int LB = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [LB-1:0] i_low,
    input  wire logic [LB-1:0] i_q,
    input  wire logic [DW-1:0] i_d,
    output logic [DW-1:0]      o_rem,
    output logic [LB-1:0]      o_low,
    output logic [LB-1:0]      o_q,
    output logic [DW-1:0]      o_d
);
    logic [DW-1:0] r_rem;
    logic [LB-1:0] r_low;
    logic [LB-1:0] r_q;
    logic [DW-1:0] r_d;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_sh   = {i_rem, i_low[LB-1]};
    assign w_ge   = (w_sh >= {1'b0, i_d});
    assign w_diff = w_sh - {1'b0, i_d};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_low <= {i_low[LB-2:0], 1'b0};
            r_q   <= {i_q[LB-2:0], w_ge};
            r_d   <= i_d;
        end
    end

    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_q   = r_q;
    assign o_d   = r_d;
endmodule
`default_nettype wire

// File: src/rdm_cordic_cell.sv
`default_nettype none
module rdm_cordic_cell import rdm_pkg::*; #(
    parameter int CW   = 27,
    parameter int STEP = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [ZW-1:0] i_z,
    output logic signed [CW-1:0]      o_x,
    output logic signed [CW-1:0]      o_y,
    output logic signed [ZW-1:0]      o_z
);
    localparam logic signed [ZW-1:0] ATAN = rdm_atan(STEP);

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;

    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[CW-1]) begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end else begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

// File: src/radial_deadzone_mapper_core.sv
`default_nettype none
// channel  dir  words                                   handshake
// i_cfg    in   index, data (inner/outer threshold)     valid/ready, ready high out of reset
// i_in     in   raw_x, raw_y                            valid/ready
// o_out    out  corrected_x/y, corrected_magnitude,     valid/ready
//               orientation
//
// Fixed pipeline of 3*SAMPLE_BITS+8 stages (56 at defaults): squares, one root
// digit per cell, one quotient bit per cell for the magnitude and for both axes.
// CORDIC angle cells run alongside and are delayed to match.
// One word per cycle; the whole chain halts while the output word waits.
// Synchronous active-low reset clears valids and the inner threshold, and sets the outer threshold to ONE.
module radial_deadzone_mapper_core import rdm_pkg::*; #(
    parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rdm_cfg_if.sink    i_cfg,
    rdm_in_if.sink     i_in,
    rdm_out_if.source  o_out
);
    localparam int SB    = SAMPLE_BITS;
    localparam int CI    = CORDIC_ITERATIONS;
    localparam int CW    = SB + 11;
    localparam int P_R   = SB + 2;
    localparam int P_MQ  = 2*SB + 3;
    localparam int P_MAG = 2*SB + 4;
    localparam int P_PR  = 2*SB + 5;
    localparam int P_AQ  = 3*SB + 6;
    localparam int P_Z   = CI + 2;
    localparam int LAT   = 3*SB + 8;
    localparam logic [SB-1:0] ONE = {1'b1, {(SB-1){1'b0}}};

    logic [SB-1:0] r_inner;
    logic [SB-1:0] r_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= '0;
            r_outer <= ONE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_INNER: r_inner <= i_cfg.data;
                CFG_OUTER: r_outer <= i_cfg.data;
            endcase
        end
    end
    assign i_cfg.ready = i_rst_n;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // sideband lines, one entry per stage
    logic signed [SB-1:0]    r_xl [LAT];
    logic signed [SB-1:0]    r_yl [LAT];
    logic [SB-1:0]           r_rl [LAT];
    logic [SB-1:0]           r_ml [LAT];
    logic signed [ORI_W-1:0] r_zl [LAT];

    logic [SB-1:0]           w_root;
    logic [SB-1:0]           w_mag;
    logic signed [ORI_W-1:0] w_zc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xl[0] <= i_in.raw_x;
            r_yl[0] <= i_in.raw_y;
            r_rl[0] <= '0;
            r_ml[0] <= '0;
            r_zl[0] <= '0;
            for (int k = 1; k < LAT; k++) begin
                r_xl[k] <= r_xl[k-1];
                r_yl[k] <= r_yl[k-1];
                r_rl[k] <= (k == P_R + 1) ? w_root : r_rl[k-1];
                r_ml[k] <= (k == P_MAG) ? w_mag : r_ml[k-1];
                r_zl[k] <= (k == P_Z) ? w_zc : r_zl[k-1];
            end
        end
    end

    // squared radius
    logic [SB-1:0]   w_ax0;
    logic [SB-1:0]   w_ay0;
    logic [2*SB-1:0] r_sqx;
    logic [2*SB-1:0] r_sqy;
    logic [2*SB-1:0] r_n;

    assign w_ax0 = r_xl[0][SB-1] ? (~$unsigned(r_xl[0]) + 1'b1) : $unsigned(r_xl[0]);
    assign w_ay0 = r_yl[0][SB-1] ? (~$unsigned(r_yl[0]) + 1'b1) : $unsigned(r_yl[0]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx <= {{SB{1'b0}}, w_ax0} * {{SB{1'b0}}, w_ax0};
            r_sqy <= {{SB{1'b0}}, w_ay0} * {{SB{1'b0}}, w_ay0};
            r_n   <= r_sqx + r_sqy;
        end
    end

    // square root chain
    logic [2*SB-1:0] w_sn    [SB+1];
    logic [SB+1:0]   w_srem  [SB+1];
    logic [SB-1:0]   w_sroot [SB+1];

    assign w_sn[0]    = r_n;
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;

    for (genvar j = 0; j < SB; j++) begin : g_sqrt
        rdm_sqrt_cell #(.SB(SB)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_n    (w_sn[j]),
            .i_rem  (w_srem[j]),
            .i_root (w_sroot[j]),
            .o_n    (w_sn[j+1]),
            .o_rem  (w_srem[j+1]),
            .o_root (w_sroot[j+1])
        );
    end
    assign w_root = w_sroot[SB];

    // magnitude division: (r - inner) * ONE / (outer - inner)
    logic [SB-1:0] w_diff;
    logic [SB-1:0] r_mrem0;
    logic [SB-1:0] r_mlow0;
    logic [SB-1:0] r_md0;

    assign w_diff = w_root - r_inner;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mrem0 <= {1'b0, w_diff[SB-1:1]};
            r_mlow0 <= {w_diff[0], {(SB-1){1'b0}}};
            r_md0   <= r_outer - r_inner;
        end
    end

    logic [SB-1:0] w_mrem [SB+1];
    logic [SB-1:0] w_mlow [SB+1];
    logic [SB-1:0] w_mq   [SB+1];
    logic [SB-1:0] w_md   [SB+1];

    assign w_mrem[0] = r_mrem0;
    assign w_mlow[0] = r_mlow0;
    assign w_mq[0]   = '0;
    assign w_md[0]   = r_md0;

    for (genvar j = 0; j < SB; j++) begin : g_mdiv
        rdm_div_cell #(.DW(SB), .LB(SB)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_mrem[j]),
            .i_low (w_mlow[j]),
            .i_q   (w_mq[j]),
            .i_d   (w_md[j]),
            .o_rem (w_mrem[j+1]),
            .o_low (w_mlow[j+1]),
            .o_q   (w_mq[j+1]),
            .o_d   (w_md[j+1])
        );
    end

    logic [SB-1:0] w_rm;
    assign w_rm = r_rl[P_MQ];

    always_comb begin
        priority if (w_rm < r_inner) begin
            w_mag = '0;
        end else if (w_rm > r_outer || r_outer == r_inner) begin
            w_mag = ONE;
        end else if (w_mq[SB] > ONE) begin
            w_mag = ONE;
        end else begin
            w_mag = w_mq[SB];
        end
    end

    // axis scaling: (2*|v|*m + r) / (2*r)
    logic [SB-1:0]   w_axm;
    logic [SB-1:0]   w_aym;
    logic [2*SB-1:0] r_pa;
    logic [2*SB-1:0] r_pb;
    logic [2*SB-1:0] w_dxa;
    logic [2*SB-1:0] w_dya;
    logic [SB:0]     r_xrem0;
    logic [SB-1:0]   r_xlow0;
    logic [SB:0]     r_yrem0;
    logic [SB-1:0]   r_ylow0;
    logic [SB:0]     r_dd0;

    assign w_axm = r_xl[P_MAG][SB-1] ? (~$unsigned(r_xl[P_MAG]) + 1'b1)
                                     : $unsigned(r_xl[P_MAG]);
    assign w_aym = r_yl[P_MAG][SB-1] ? (~$unsigned(r_yl[P_MAG]) + 1'b1)
                                     : $unsigned(r_yl[P_MAG]);
    assign w_dxa = {r_pa[2*SB-2:0], 1'b0} + {{SB{1'b0}}, r_rl[P_PR]};
    assign w_dya = {r_pb[2*SB-2:0], 1'b0} + {{SB{1'b0}}, r_rl[P_PR]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa    <= {{SB{1'b0}}, w_axm} * {{SB{1'b0}}, r_ml[P_MAG]};
            r_pb    <= {{SB{1'b0}}, w_aym} * {{SB{1'b0}}, r_ml[P_MAG]};
            r_xrem0 <= {1'b0, w_dxa[2*SB-1:SB]};
            r_xlow0 <= w_dxa[SB-1:0];
            r_yrem0 <= {1'b0, w_dya[2*SB-1:SB]};
            r_ylow0 <= w_dya[SB-1:0];
            r_dd0   <= {r_rl[P_PR], 1'b0};
        end
    end

    logic [SB:0]   w_xrem [SB+1];
    logic [SB-1:0] w_xlow [SB+1];
    logic [SB-1:0] w_xq   [SB+1];
    logic [SB:0]   w_xd   [SB+1];
    logic [SB:0]   w_yrem [SB+1];
    logic [SB-1:0] w_ylow [SB+1];
    logic [SB-1:0] w_yq   [SB+1];
    logic [SB:0]   w_yd   [SB+1];

    assign w_xrem[0] = r_xrem0;
    assign w_xlow[0] = r_xlow0;
    assign w_xq[0]   = '0;
    assign w_xd[0]   = r_dd0;
    assign w_yrem[0] = r_yrem0;
    assign w_ylow[0] = r_ylow0;
    assign w_yq[0]   = '0;
    assign w_yd[0]   = r_dd0;

    for (genvar j = 0; j < SB; j++) begin : g_adiv
        rdm_div_cell #(.DW(SB+1), .LB(SB)) u_xcell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_xrem[j]),
            .i_low (w_xlow[j]),
            .i_q   (w_xq[j]),
            .i_d   (w_xd[j]),
            .o_rem (w_xrem[j+1]),
            .o_low (w_xlow[j+1]),
            .o_q   (w_xq[j+1]),
            .o_d   (w_xd[j+1])
        );
        rdm_div_cell #(.DW(SB+1), .LB(SB)) u_ycell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_yrem[j]),
            .i_low (w_ylow[j]),
            .i_q   (w_yq[j]),
            .i_d   (w_yd[j]),
            .o_rem (w_yrem[j+1]),
            .o_low (w_ylow[j+1]),
            .o_q   (w_yq[j+1]),
            .o_d   (w_yd[j+1])
        );
    end

    // CORDIC angle, quarter pre-rotation for left half plane
    logic signed [CW-1:0] w_x0;
    logic signed [CW-1:0] w_y0;
    logic signed [CW-1:0] w_cx [CI+1];
    logic signed [CW-1:0] w_cy [CI+1];
    logic signed [ZW-1:0] w_cz [CI+1];
    logic signed [CW-1:0] r_cx0;
    logic signed [CW-1:0] r_cy0;
    logic signed [ZW-1:0] r_cz0;

    assign w_x0 = {{3{r_xl[0][SB-1]}}, r_xl[0], 8'h00};
    assign w_y0 = {{3{r_yl[0][SB-1]}}, r_yl[0], 8'h00};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_x0[CW-1]) begin
                if (!w_y0[CW-1]) begin
                    r_cx0 <= w_y0;
                    r_cy0 <= -w_x0;
                    r_cz0 <= ANGLE_90;
                end else begin
                    r_cx0 <= -w_y0;
                    r_cy0 <= w_x0;
                    r_cz0 <= -ANGLE_90;
                end
            end else begin
                r_cx0 <= w_x0;
                r_cy0 <= w_y0;
                r_cz0 <= '0;
            end
        end
    end

    assign w_cx[0] = r_cx0;
    assign w_cy[0] = r_cy0;
    assign w_cz[0] = r_cz0;

    for (genvar j = 0; j < CI; j++) begin : g_cordic
        rdm_cordic_cell #(.CW(CW), .STEP(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_cx[j]),
            .i_y   (w_cy[j]),
            .i_z   (w_cz[j]),
            .o_x   (w_cx[j+1]),
            .o_y   (w_cy[j+1]),
            .o_z   (w_cz[j+1])
        );
    end

    logic signed [ZW-1:0] w_zs;
    logic signed [ZW-1:0] w_zr;

    assign w_zs = w_cz[CI] + Z_HALF;
    assign w_zr = w_zs >>> 16;

    always_comb begin
        priority if (w_zr > ORI_LIMIT) begin
            w_zc = ORI_LIMIT[ORI_W-1:0];
        end else if (w_zr < -ORI_LIMIT) begin
            w_zc = ORI_W'(-ORI_LIMIT);
        end else begin
            w_zc = w_zr[ORI_W-1:0];
        end
    end

    // output word
    logic [SB-1:0]           w_ma;
    logic [SB-1:0]           w_ra;
    logic signed [SB:0]      w_qx;
    logic signed [SB:0]      w_qy;
    logic signed [SB:0]      r_ocx;
    logic signed [SB:0]      r_ocy;
    logic [SB-1:0]           r_omag;
    logic signed [ORI_W-1:0] r_oori;

    assign w_ma = r_ml[P_AQ];
    assign w_ra = r_rl[P_AQ];
    assign w_qx = $signed({1'b0, w_xq[SB]});
    assign w_qy = $signed({1'b0, w_yq[SB]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_omag <= w_ma;
            priority if (w_ma == '0) begin
                r_ocx  <= '0;
                r_ocy  <= '0;
                r_oori <= '0;
            end else if (w_ra == '0) begin
                // zero radius: angle taken as zero
                r_ocx  <= $signed({1'b0, w_ma});
                r_ocy  <= '0;
                r_oori <= '0;
            end else begin
                r_ocx  <= r_xl[P_AQ][SB-1] ? -w_qx : w_qx;
                r_ocy  <= r_yl[P_AQ][SB-1] ? -w_qy : w_qy;
                r_oori <= r_zl[P_AQ];
            end
        end
    end

    assign o_out.valid               = r_vld[LAT-1];
    assign o_out.corrected_x         = r_ocx;
    assign o_out.corrected_y         = r_ocy;
    assign o_out.corrected_magnitude = r_omag;
    assign o_out.orientation         = r_oori;

    a_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.corrected_magnitude == '0) |->
        (o_out.corrected_x == '0 && o_out.corrected_y == '0 && o_out.orientation == '0))
        else $error("nonzero position with zero magnitude");

    a_mag_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.corrected_magnitude <= ONE))
        else $error("magnitude above one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// File: tb/tb_radial_deadzone_mapper_core.sv
module tb_radial_deadzone_mapper_core;
    import rdm_pkg::*;

    localparam int  LATENCY   = 56;
    localparam int  MAX_CYC   = 400000;
    localparam int  ONE       = 32768;

    typedef struct packed {
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic [15:0]        mag;
        logic signed [14:0] ori;
    } t_stick_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rdm_cfg_if #(.SB(16)) cfg_ch ();
    rdm_in_if  #(.SB(16)) in_ch ();
    rdm_out_if #(.SB(16)) out_ch ();

    radial_deadzone_mapper_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // thresholds as the predictor sees them
    logic [15:0] inner_thr = 16'd0;
    logic [15:0] outer_thr = 16'd32768;

    t_stick_word expected_q[$];
    int          n_errors = 0;
    int          cycle_cnt = 0;
    int          rx_wait = 0;
    bit          hold_off = 1'b0;

    function automatic longint floor_sh(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint root_floor(longint n);
        longint lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint stick_angle(longint x, longint y);
        longint ax, ay, z, t, dx, dy;
        ax = x * 256;
        ay = y * 256;
        z  = 0;
        if (ax < 0) begin
            t = ax;
            if (ay >= 0) begin
                ax = ay; ay = -t; z = ANGLE_90;
            end else begin
                ax = -ay; ay = t; z = -ANGLE_90;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_sh(ay, i);
            dy = floor_sh(ax, i);
            if (ay >= 0) begin
                ax += dx; ay -= dy; z += rdm_atan(i);
            end else begin
                ax -= dx; ay += dy; z -= rdm_atan(i);
            end
        end
        z = floor_sh(z + 32768, 16);
        if (z > 11520) z = 11520;
        if (z < -11520) z = -11520;
        return z;
    endfunction

    function automatic longint scale_to_mag(longint v, longint m, longint r);
        longint a, q;
        a = (v < 0) ? -v : v;
        q = (2 * a * m + r) / (2 * r);
        return (v < 0) ? -q : q;
    endfunction

    function automatic t_stick_word map_stick(logic signed [15:0] rx, logic signed [15:0] ry);
        longint x, y, r, m, inr, outr;
        t_stick_word w;
        x = rx;
        y = ry;
        inr = inner_thr;
        outr = outer_thr;
        r = root_floor(x * x + y * y);
        if (r < inr)
            m = 0;
        else if (r > outr || outr == inr)
            m = ONE;
        else begin
            m = (r - inr) * ONE / (outr - inr);
            if (m > ONE) m = ONE;
        end
        w = '0;
        w.mag = m[15:0];
        if (m != 0) begin
            if (r == 0) begin
                w.cx = m[16:0];
            end else begin
                w.cx  = 17'(scale_to_mag(x, m, r));
                w.cy  = 17'(scale_to_mag(y, m, r));
                w.ori = 15'(stick_angle(x, y));
            end
        end
        return w;
    endfunction

    task automatic report(string what, longint got, longint exp);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycle_cnt);
        n_errors++;
    endtask

    // valid stays high into the next word when no gap follows
    task automatic send_stick(logic signed [15:0] rx, logic signed [15:0] ry, bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_x <= rx;
        in_ch.raw_y <= ry;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_q.push_back(map_stick(rx, ry));
    endtask

    task automatic write_thr(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_INNER) inner_thr = val;
        else outer_thr = val;
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_thresholds(logic [15:0] inr, logic [15:0] outr);
        drain();
        write_thr(CFG_INNER, inr);
        write_thr(CFG_OUTER, outr);
        cfg_ch.valid <= 1'b0;
    endtask

    // receiver: random wait per word, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            rx_wait = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) rx_wait = 0;
        end
        if (!i_rst_n || hold_off) begin
            out_ch.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            out_ch.ready <= 1'b0;
            rx_wait--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_stick_word e;
        cycle_cnt++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected word", out_ch.corrected_magnitude, 0);
            end else begin
                e = expected_q.pop_front();
                if (out_ch.corrected_x !== e.cx) report("corrected_x", out_ch.corrected_x, e.cx);
                if (out_ch.corrected_y !== e.cy) report("corrected_y", out_ch.corrected_y, e.cy);
                if (out_ch.corrected_magnitude !== e.mag)
                    report("corrected_magnitude", out_ch.corrected_magnitude, e.mag);
                if (out_ch.orientation !== e.ori) report("orientation", out_ch.orientation, e.ori);
            end
        end
        if (cycle_cnt > MAX_CYC) begin
            $display("timeout at cycle %0d", cycle_cnt);
            $display("** radial_deadzone_mapper_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic test_extremes;
        send_stick(16'sh7fff, 16'sd0);
        send_stick(-16'sh8000, 16'sd0);
        send_stick(16'sd0, 16'sh7fff);
        send_stick(16'sd0, -16'sh8000);
        send_stick(-16'sh8000, -16'sh8000);
        send_stick(16'sh7fff, 16'sh7fff);
        send_stick(-16'sh8000, 16'sh7fff);
        send_stick(16'sd0, 16'sd0);
        send_stick(-16'sd1, 16'sd0);
        send_stick(-16'sd100, -16'sd1);
        send_stick(-16'sh5555, 16'sh2aaa);
    endtask

    task automatic test_dead_zone_edges;
        set_thresholds(16'd5000, 16'd20000);
        send_stick(16'sd4999, 16'sd0);  // inside
        send_stick(16'sd5000, 16'sd0);  // mapped to zero
        send_stick(16'sd3000, 16'sd4000);
        send_stick(16'sd12000, -16'sd9000);
        send_stick(16'sd20000, 16'sd0);
        send_stick(-16'sd20001, 16'sd0); // beyond outer
        set_thresholds(16'd10000, 16'd10000); // equal thresholds
        send_stick(16'sd10000, 16'sd0);
        send_stick(16'sd6000, 16'sd8000);
        send_stick(16'sd9999, 16'sd0);
        set_thresholds(16'd20000, 16'd3000); // inner above outer
        send_stick(16'sd20000, 16'sd1);
        send_stick(16'sd100, 16'sd0);
        set_thresholds(16'd0, 16'd0); // zero radius saturates
        send_stick(16'sd0, 16'sd0);
        send_stick(-16'sd7, 16'sd3);
        set_thresholds(16'hffff, 16'hffff);
        send_stick(-16'sh8000, -16'sh8000);
    endtask

    task automatic test_random(int n);
        int sel;
        logic signed [15:0] rx, ry;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0: set_thresholds(16'd0, 16'd32768);
                    1: set_thresholds(16'hffff, 16'hffff);
                    2: set_thresholds(16'd0, 16'd0);
                    3: set_thresholds(rnd16(), rnd16());
                    default: set_thresholds(16'($urandom_range(0, 16000)),
                                            16'($urandom_range(16000, 32768)));
                endcase
            end
            rx = rnd16();
            ry = rnd16();
            if ($urandom_range(0, 3) == 0) begin
                // keep radius near the thresholds
                rx = $signed(16'($urandom_range(0, 2) == 0 ? inner_thr : outer_thr))
                     + $signed(16'($urandom_range(0, 4))) - 16'sd2;
                ry = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom_range(0, 3));
            end
            send_stick(rx, ry, i % 150 < 100);
        end
    endtask

    task automatic test_back_pressure;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 120; i++) send_stick(rnd16(), rnd16(), 1'b0);
        join
    endtask

    initial begin
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_INNER;
        cfg_ch.data  <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.raw_x  <= '0;
        in_ch.raw_y  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_dead_zone_edges();
        test_back_pressure();
        test_random(600);
        drain();
        repeat (LATENCY * 2) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("** radial_deadzone_mapper_core: PASSED **");
        else
            $display("** radial_deadzone_mapper_core: FAILED **");
        $finish;
    end
endmodule
